### sv/rnv_pkg.sv
// Shared constants, defaults and types of the RGB to NV12 upscaling converter.
package rnv_pkg;

  localparam int RNV_MAX_WIDTH  = 512;
  localparam int RNV_MAX_HEIGHT = 512;
  localparam int RNV_MAX_SCALE  = 8;

  localparam int RNV_DIM_W     = 10;
  localparam int RNV_SCALE_W   = 4;
  localparam int RNV_PIX_W     = 24;
  localparam int RNV_APB_DW    = 32;
  localparam int RNV_PADDR_W   = 4;
  localparam int RNV_REG_IDX_W = 2;

  localparam logic [RNV_REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [RNV_REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [RNV_REG_IDX_W-1:0] REG_SCALE      = 2'd2;

  localparam logic [RNV_DIM_W-1:0]   RST_SRC_WIDTH  = 10'd320;
  localparam logic [RNV_DIM_W-1:0]   RST_SRC_HEIGHT = 10'd256;
  localparam logic [RNV_SCALE_W-1:0] RST_SCALE      = 4'd1;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } rnv_csc_t;

endpackage

### sv/rnv_in_if.sv
// Input channel carrying load and emit transactions.
interface rnv_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, action, red, green, blue, input ready);
  modport sink (input valid, action, red, green, blue, output ready);
endinterface

### sv/rnv_out_if.sv
// Output channel carrying NV12 byte transactions.
interface rnv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic       plane;
  logic       last;

  modport source (output valid, value, plane, last, input ready);
  modport sink (input valid, value, plane, last, output ready);
endinterface

### sv/rgb_to_nv12_upscaling_converter_top.sv
// Top level of the RGB to NV12 converter with nearest-neighbor upscaling.
//
//   Channel  Direction  Handshake            Transaction
//   in_i     sink       valid/ready          load one RGB pixel or request one NV12 byte
//   out_o    source     valid/ready          one NV12 byte with plane and last flags
//   APB      slave      psel/penable/pready  write or read of a configuration register
//
// A load leaves the sequencer idle. A luma byte passes two divisions, one read, a wait and
// the calculation step before the next transaction is taken; an even chroma byte passes
// four divisions and four reads, an odd one only the calculation step. One shared reciprocal
// multiplier does the coordinate divisions; one frame store read port serves the samples in turn.
// Reset clears control state only; the frame store holds no data until it is loaded.
// A finished byte waits in the output register, and the next byte stalls in its last step.
module rgb_to_nv12_upscaling_converter_top
  import rnv_pkg::*;
#(
  parameter int MAX_WIDTH  = RNV_MAX_WIDTH,
  parameter int MAX_HEIGHT = RNV_MAX_HEIGHT,
  parameter int MAX_SCALE  = RNV_MAX_SCALE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  rnv_in_if.sink                 in_i,
  rnv_out_if.source              out_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [RNV_PADDR_W-1:0] paddr,
  input  logic [RNV_APB_DW-1:0]  pwdata,
  output logic [RNV_APB_DW-1:0]  prdata,
  output logic                   pready
);

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int SW_W    = $clog2(MAX_WIDTH + 1);
  localparam int SH_W    = $clog2(MAX_HEIGHT + 1);
  localparam int SFW     = $clog2(MAX_SCALE + 1);
  localparam int WMAX    = MAX_WIDTH * MAX_SCALE;
  localparam int HMAX    = MAX_HEIGHT * MAX_SCALE;
  localparam int LEN_MAX = WMAX + (WMAX % 2);
  localparam int COLW    = $clog2(LEN_MAX);
  localparam int LENW    = $clog2(LEN_MAX + 1);
  localparam int ROWW    = $clog2(HMAX);
  localparam int HW      = $clog2(HMAX + 1);
  localparam int DW      = (LENW > ROWW + 1) ? LENW : ROWW + 1;
  localparam int SHIFT   = DW + SFW;
  localparam int RW      = SHIFT + 1;
  localparam int PRODW   = DW + RW;
  localparam int WCW     = (SW_W > RNV_DIM_W) ? SW_W : RNV_DIM_W;
  localparam int HCW     = (SH_W > RNV_DIM_W) ? SH_W : RNV_DIM_W;
  localparam int SCW     = (SFW > RNV_SCALE_W) ? SFW : RNV_SCALE_W;
  localparam int CMPW0   = (DW > SW_W) ? DW : SW_W;
  localparam int CMPW    = (CMPW0 > SH_W) ? CMPW0 : SH_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_CALC = 3'd4;

  // Configuration registers.
  logic [RNV_DIM_W-1:0]   cfg_w_q, cfg_h_q;
  logic [RNV_SCALE_W-1:0] cfg_sf_q;
  logic                   cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= RST_SRC_WIDTH;
      cfg_h_q  <= RST_SRC_HEIGHT;
      cfg_sf_q <= RST_SCALE;
    end else if (cfg_we) begin
      case (paddr[RNV_REG_IDX_W+1:2])
        REG_SRC_WIDTH:  cfg_w_q  <= pwdata[RNV_DIM_W-1:0];
        REG_SRC_HEIGHT: cfg_h_q  <= pwdata[RNV_DIM_W-1:0];
        REG_SCALE:      cfg_sf_q <= pwdata[RNV_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[RNV_REG_IDX_W+1:2])
      REG_SRC_WIDTH:  prdata = RNV_APB_DW'(cfg_w_q);
      REG_SRC_HEIGHT: prdata = RNV_APB_DW'(cfg_h_q);
      REG_SCALE:      prdata = RNV_APB_DW'(cfg_sf_q);
      default:        prdata = '0;
    endcase
  end

  // Effective dimensions and scale.
  logic [SW_W-1:0] eff_w;
  logic [SH_W-1:0] eff_h;
  logic [SFW-1:0]  eff_sf;

  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = SW_W'(1);
    end else if (WCW'(cfg_w_q) > WCW'(MAX_WIDTH)) begin
      eff_w = SW_W'(MAX_WIDTH);
    end else begin
      eff_w = SW_W'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = SH_W'(1);
    end else if (HCW'(cfg_h_q) > HCW'(MAX_HEIGHT)) begin
      eff_h = SH_W'(MAX_HEIGHT);
    end else begin
      eff_h = SH_W'(cfg_h_q);
    end
    if (cfg_sf_q == '0) begin
      eff_sf = SFW'(1);
    end else if (SCW'(cfg_sf_q) > SCW'(MAX_SCALE)) begin
      eff_sf = SFW'(MAX_SCALE);
    end else begin
      eff_sf = SFW'(cfg_sf_q);
    end
  end

  logic [SW_W+SFW-1:0] w_prod;
  logic [SH_W+SFW-1:0] h_prod;
  logic [LENW-1:0]     scaled_w_q;
  logic [HW-1:0]       scaled_h_q;

  assign w_prod = {{SFW{1'b0}}, eff_w} * {{SW_W{1'b0}}, eff_sf};
  assign h_prod = {{SFW{1'b0}}, eff_h} * {{SH_W{1'b0}}, eff_sf};

  always_ff @(posedge clk_i) begin
    scaled_w_q <= LENW'(w_prod);
    scaled_h_q <= HW'(h_prod);
  end

  // Reciprocals of the scale factor for division by multiplication.
  logic [RW-1:0] recip_tbl [2**SFW];

  for (genvar Gi = 0; Gi < 2**SFW; Gi = Gi + 1) begin : g_recip
    localparam longint unsigned Den = (Gi == 0) ? 1 : Gi;
    localparam logic [RW-1:0] Rcp = RW'(((64'd1 << SHIFT) + Den - 1) / Den);
    assign recip_tbl[Gi] = Rcp;
  end

  // Sequencer and emit position.
  logic [2:0]      state_q, state_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      samp_q, samp_d;
  logic [COLW-1:0] pos_col_q, pos_col_d;
  logic [ROWW-1:0] pos_row_q, pos_row_d;
  logic            chroma_q, chroma_d;
  logic [7:0]      held_v_q, held_v_d;
  logic            rd_vld_q;
  logic [DW-1:0]   qx0_q, qx1_q, qy0_q, qy1_q;
  logic [9:0]      sum_r_q, sum_g_q, sum_b_q;
  logic            out_vld_q;
  logic [7:0]      out_value_q;
  logic            out_plane_q, out_last_q;

  logic             in_acc, ld_en, emit_acc, rd_en, adv;
  logic [DW-1:0]    crd_x, crd_y, div_coord;
  logic [PRODW-1:0] div_prod;
  logic [DW-1:0]    div_quot;
  logic [DW-1:0]    sel_x, sel_y;
  logic [XW-1:0]    src_x;
  logic [YW-1:0]    src_y;
  logic [RNV_PIX_W-1:0] rd_data;
  logic [7:0]       avg_r, avg_g, avg_b;
  rnv_csc_t         csc;
  logic [LENW-1:0]  rowlen, col_inc;
  logic [HW-1:0]    rows, row_inc;
  logic             last_d;
  logic [7:0]       value_d;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ld_en      = in_acc && !in_i.action;
  assign emit_acc   = in_acc && in_i.action;
  assign rd_en      = (state_q == ST_READ);
  assign adv        = (state_q == ST_CALC) && (!out_vld_q || out_o.ready);

  always_comb begin
    crd_x = DW'(pos_col_q);
    crd_y = chroma_q ? DW'({pos_row_q, 1'b0}) : DW'(pos_row_q);
    case (cnt_q)
      2'd0:    div_coord = crd_x;
      2'd1:    div_coord = crd_x + DW'(1);
      2'd2:    div_coord = crd_y;
      default: div_coord = crd_y + DW'(1);
    endcase
    div_prod = PRODW'(div_coord) * PRODW'(recip_tbl[eff_sf]);
    div_quot = div_prod[SHIFT +: DW];
  end

  always_comb begin
    sel_x = samp_q[0] ? qx1_q : qx0_q;
    sel_y = samp_q[1] ? qy1_q : qy0_q;
    src_x = (CMPW'(sel_x) >= CMPW'(eff_w)) ? XW'(eff_w - SW_W'(1)) : XW'(sel_x);
    src_y = (CMPW'(sel_y) >= CMPW'(eff_h)) ? YW'(eff_h - SH_W'(1)) : YW'(sel_y);
  end

  rnv_frame_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .eff_w_i  (eff_w),
    .eff_h_i  (eff_h),
    .load_i   (ld_en),
    .pix_i    ({in_i.red, in_i.green, in_i.blue}),
    .rd_en_i  (rd_en),
    .rd_addr_i({src_y, src_x}),
    .rd_data_o(rd_data)
  );

  assign avg_r = chroma_q ? sum_r_q[9:2] : sum_r_q[7:0];
  assign avg_g = chroma_q ? sum_g_q[9:2] : sum_g_q[7:0];
  assign avg_b = chroma_q ? sum_b_q[9:2] : sum_b_q[7:0];

  rnv_csc u_csc (
    .red_i  (avg_r),
    .green_i(avg_g),
    .blue_i (avg_b),
    .csc_o  (csc)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    samp_d    = samp_q;
    pos_col_d = pos_col_q;
    pos_row_d = pos_row_q;
    chroma_d  = chroma_q;
    held_v_d  = held_v_q;
    last_d    = 1'b0;
    value_d   = csc.y;
    rowlen    = chroma_q ? scaled_w_q + LENW'(scaled_w_q[0]) : scaled_w_q;
    rows      = chroma_q ? HW'(({1'b0, scaled_h_q} + (HW + 1)'(1)) >> 1) : scaled_h_q;
    col_inc   = LENW'(pos_col_q) + LENW'(1);
    row_inc   = HW'(pos_row_q) + HW'(1);
    if (chroma_q) begin
      value_d = pos_col_q[0] ? held_v_q : csc.u;
    end
    case (state_q)
      ST_IDLE: begin
        if (emit_acc) begin
          cnt_d   = 2'd0;
          samp_d  = 2'd0;
          state_d = (chroma_q && pos_col_q[0]) ? ST_CALC : ST_DIV;
        end
      end
      ST_DIV: begin
        case (cnt_q)
          2'd0:    cnt_d = chroma_q ? 2'd1 : 2'd2;
          2'd1:    cnt_d = 2'd2;
          2'd2: begin
            cnt_d = 2'd3;
            if (!chroma_q) begin
              state_d = ST_READ;
            end
          end
          default: state_d = ST_READ;
        endcase
      end
      ST_READ: begin
        if (!chroma_q || samp_q == 2'd3) begin
          state_d = ST_WAIT;
        end else begin
          samp_d = samp_q + 2'd1;
        end
      end
      ST_WAIT: state_d = ST_CALC;
      ST_CALC: begin
        if (adv) begin
          state_d = ST_IDLE;
          if (chroma_q && !pos_col_q[0]) begin
            held_v_d = csc.v;
          end
          if (col_inc >= rowlen) begin
            pos_col_d = '0;
            if (row_inc >= rows) begin
              pos_row_d = '0;
              last_d    = chroma_q;
              chroma_d  = !chroma_q;
            end else begin
              pos_row_d = ROWW'(row_inc);
            end
          end else begin
            pos_col_d = COLW'(col_inc);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      samp_q    <= '0;
      pos_col_q <= '0;
      pos_row_q <= '0;
      chroma_q  <= 1'b0;
      held_v_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      samp_q    <= samp_d;
      pos_col_q <= pos_col_d;
      pos_row_q <= pos_row_d;
      chroma_q  <= chroma_d;
      held_v_q  <= held_v_d;
      rd_vld_q  <= rd_en;
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      case (cnt_q)
        2'd0:    qx0_q <= div_quot;
        2'd1:    qx1_q <= div_quot;
        2'd2:    qy0_q <= div_quot;
        default: qy1_q <= div_quot;
      endcase
    end
    if (emit_acc) begin
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
    end else if (rd_vld_q) begin
      sum_r_q <= sum_r_q + 10'(rd_data[23:16]);
      sum_g_q <= sum_g_q + 10'(rd_data[15:8]);
      sum_b_q <= sum_b_q + 10'(rd_data[7:0]);
    end
    if (adv) begin
      out_value_q <= value_d;
      out_plane_q <= chroma_q;
      out_last_q  <= last_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.value = out_value_q;
  assign out_o.plane = out_plane_q;
  assign out_o.last  = out_last_q;

  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld_en && rd_en))
    else $error("Frame store written and read in the same cycle.");

  a_emit_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_acc |=> (state_q != ST_IDLE))
    else $error("Emit transaction accepted without starting work.");

  a_last_is_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |-> out_plane_q)
    else $error("Last flag raised on a luma byte.");

  a_luma_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && !chroma_q) |-> (samp_q == 2'd0))
    else $error("Luma byte issued more than one frame store read.");

endmodule

### sv/rnv_csc.sv
// BT.601 integer color conversion of one RGB sample to saturated Y, U and V bytes.
module rnv_csc
  import rnv_pkg::*;
(
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output rnv_csc_t   csc_o
);

  localparam logic signed [17:0] YR = 18'sd66;
  localparam logic signed [17:0] YG = 18'sd129;
  localparam logic signed [17:0] YB = 18'sd25;
  localparam logic signed [17:0] UR = 18'sd38;
  localparam logic signed [17:0] UG = 18'sd74;
  localparam logic signed [17:0] UB = 18'sd112;
  localparam logic signed [17:0] VR = 18'sd112;
  localparam logic signed [17:0] VG = 18'sd94;
  localparam logic signed [17:0] VB = 18'sd18;
  // Rounding term plus the output offset moved in front of the shift.
  localparam logic signed [17:0] Y_BIAS = 18'sd4224;
  localparam logic signed [17:0] C_BIAS = 18'sd32896;

  function automatic logic [7:0] sat_shift(input logic signed [17:0] t);
    logic signed [9:0] s;
    s = t[17:8];
    if (s[9]) begin
      sat_shift = 8'd0;
    end else if (s > 10'sd255) begin
      sat_shift = 8'hFF;
    end else begin
      sat_shift = s[7:0];
    end
  endfunction

  logic signed [17:0] r_s, g_s, b_s;
  logic signed [17:0] t_y, t_u, t_v;

  always_comb begin
    r_s = signed'({10'd0, red_i});
    g_s = signed'({10'd0, green_i});
    b_s = signed'({10'd0, blue_i});
    t_y = YR * r_s + YG * g_s + YB * b_s + Y_BIAS;
    t_u = UB * b_s - UR * r_s - UG * g_s + C_BIAS;
    t_v = VR * r_s - VG * g_s - VB * b_s + C_BIAS;
    csc_o.y = sat_shift(t_y);
    csc_o.u = sat_shift(t_u);
    csc_o.v = sat_shift(t_v);
  end

endmodule

### sv/rnv_frame_store.sv
// Source frame store with raster load addressing and a registered read port.
module rnv_frame_store
  import rnv_pkg::*;
#(
  parameter int MAX_WIDTH  = RNV_MAX_WIDTH,
  parameter int MAX_HEIGHT = RNV_MAX_HEIGHT,
  localparam int XW   = $clog2(MAX_WIDTH),
  localparam int YW   = $clog2(MAX_HEIGHT),
  localparam int SW_W = $clog2(MAX_WIDTH + 1),
  localparam int SH_W = $clog2(MAX_HEIGHT + 1),
  localparam int AW   = XW + YW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SW_W-1:0]      eff_w_i,
  input  logic [SH_W-1:0]      eff_h_i,
  input  logic                 load_i,
  input  logic [RNV_PIX_W-1:0] pix_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [RNV_PIX_W-1:0] rd_data_o
);

  logic [RNV_PIX_W-1:0] store_q [2**AW];
  logic [RNV_PIX_W-1:0] rd_data_q;
  logic [XW-1:0]        load_col_q, load_col_d, wr_col;
  logic [YW-1:0]        load_row_q, load_row_d, wr_row;
  logic [SW_W-1:0]      col_ext;
  logic [SH_W-1:0]      row_ext;

  always_comb begin
    col_ext = SW_W'(load_col_q);
    row_ext = SH_W'(load_row_q);
    wr_col  = (col_ext >= eff_w_i) ? XW'(eff_w_i - SW_W'(1)) : load_col_q;
    wr_row  = (row_ext >= eff_h_i) ? YW'(eff_h_i - SH_W'(1)) : load_row_q;
    load_col_d = load_col_q;
    load_row_d = load_row_q;
    if (load_i) begin
      if (col_ext + SW_W'(1) >= eff_w_i) begin
        load_col_d = '0;
        if (row_ext + SH_W'(1) >= eff_h_i) begin
          load_row_d = '0;
        end else begin
          load_row_d = load_row_q + YW'(1);
        end
      end else begin
        load_col_d = load_col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_col_q <= '0;
      load_row_q <= '0;
    end else begin
      load_col_q <= load_col_d;
      load_row_q <= load_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      store_q[{wr_row, wr_col}] <= pix_i;
    end
    if (rd_en_i) begin
      rd_data_q <= store_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### bench/testbench.sv
// Self-checking testbench of the RGB to NV12 upscaling converter, built around a scoreboard class.
module testbench;
  import rnv_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int STORE_DEPTH  = RNV_MAX_WIDTH * RNV_MAX_HEIGHT;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_EMIT     = 1'b1;
  localparam logic PLANE_LUMA   = 1'b0;
  localparam logic PLANE_CHROMA = 1'b1;

  typedef struct packed {
    logic [7:0] value;
    logic       plane;
    logic       last;
  } nv12_byte_t;

  class nv12_scoreboard;
    logic [RNV_PIX_W-1:0]   pixels [STORE_DEPTH];
    bit                     written [STORE_DEPTH];
    logic [RNV_DIM_W-1:0]   width_reg  = RST_SRC_WIDTH;
    logic [RNV_DIM_W-1:0]   height_reg = RST_SRC_HEIGHT;
    logic [RNV_SCALE_W-1:0] scale_reg  = RST_SCALE;
    int unsigned            load_x = 0, load_y = 0, emit_x = 0, emit_y = 0;
    logic                   chroma = PLANE_LUMA;
    logic [7:0]             held_v = '0;
    nv12_byte_t             expected_bytes [$];
    int                     errors = 0;

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void set_reg(logic [RNV_REG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_SRC_WIDTH: begin
          width_reg = data[RNV_DIM_W-1:0];
        end
        REG_SRC_HEIGHT: begin
          height_reg = data[RNV_DIM_W-1:0];
        end
        REG_SCALE: begin
          scale_reg = data[RNV_SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned clip(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function int unsigned src_w();
      return clip(32'(width_reg), RNV_MAX_WIDTH);
    endfunction

    function int unsigned src_h();
      return clip(32'(height_reg), RNV_MAX_HEIGHT);
    endfunction

    function int unsigned factor();
      return clip(32'(scale_reg), RNV_MAX_SCALE);
    endfunction

    function int unsigned store_index(int unsigned x, int unsigned y);
      int unsigned sx, sy;
      sx = x / factor();
      sy = y / factor();
      if (sx >= src_w()) sx = src_w() - 1;
      if (sy >= src_h()) sy = src_h() - 1;
      return sy * RNV_MAX_WIDTH + sx;
    endfunction

    function logic [7:0] sat8(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    // True when the next byte reads only frame store entries that hold loaded data.
    function bit can_emit();
      if (chroma == PLANE_LUMA) return written[store_index(emit_x, emit_y)];
      if (emit_x[0]) return 1'b1;
      return written[store_index(emit_x, 2 * emit_y)] &&
             written[store_index(emit_x + 1, 2 * emit_y)] &&
             written[store_index(emit_x, 2 * emit_y + 1)] &&
             written[store_index(emit_x + 1, 2 * emit_y + 1)];
    endfunction

    function nv12_byte_t predict_nv12_byte();
      int unsigned w, h, rowlen, rows, rs, gs, bs, idx;
      logic [RNV_PIX_W-1:0] p;
      int t, ra, ga, ba, tu, tv;
      nv12_byte_t res;
      w = src_w() * factor();
      h = src_h() * factor();
      res.plane = chroma;
      res.last = 1'b0;
      if (chroma == PLANE_LUMA) begin
        p = pixels[store_index(emit_x, emit_y)];
        t = 66 * int'(p[23:16]) + 129 * int'(p[15:8]) + 25 * int'(p[7:0]) + 128;
        res.value = sat8((t >>> 8) + 16);
        rowlen = w;
        rows = h;
      end else begin
        rowlen = w + (w & 1);
        rows = (h + 1) / 2;
        if (!emit_x[0]) begin
          rs = 0;
          gs = 0;
          bs = 0;
          for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
              idx = store_index(emit_x + dx, 2 * emit_y + dy);
              p = pixels[idx];
              rs += 32'(p[23:16]);
              gs += 32'(p[15:8]);
              bs += 32'(p[7:0]);
            end
          end
          ra = int'(rs / 4);
          ga = int'(gs / 4);
          ba = int'(bs / 4);
          tu = -38 * ra - 74 * ga + 112 * ba + 128 + 32768;
          tv = 112 * ra - 94 * ga - 18 * ba + 128 + 32768;
          res.value = sat8(tu >>> 8);
          held_v = sat8(tv >>> 8);
        end else begin
          res.value = held_v;
        end
      end
      if (emit_x + 1 >= rowlen) begin
        emit_x = 0;
        if (emit_y + 1 >= rows) begin
          emit_y = 0;
          if (chroma == PLANE_CHROMA) res.last = 1'b1;
          chroma = ~chroma;
        end else begin
          emit_y = (emit_y + 1) & 32'hFFF;
        end
      end else begin
        emit_x = (emit_x + 1) & 32'hFFF;
      end
      return res;
    endfunction

    function void note_input(logic act, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      int unsigned col, row;
      if (act == ACT_LOAD) begin
        col = (load_x >= src_w()) ? src_w() - 1 : load_x;
        row = (load_y >= src_h()) ? src_h() - 1 : load_y;
        pixels[row * RNV_MAX_WIDTH + col] = {red, green, blue};
        written[row * RNV_MAX_WIDTH + col] = 1'b1;
        if (load_x + 1 >= src_w()) begin
          load_x = 0;
          load_y = (load_y + 1 >= src_h()) ? 0 : load_y + 1;
        end else begin
          load_x++;
        end
      end else begin
        expected_bytes.push_back(predict_nv12_byte());
      end
    endfunction

    function void check_result(logic [7:0] value, logic plane, logic last);
      nv12_byte_t want;
      if (expected_bytes.size() == 0) begin
        fail($sformatf("Unexpected byte: value %0d plane %0d last %0d", value, plane, last));
        return;
      end
      want = expected_bytes.pop_front();
      if (value !== want.value || plane !== want.plane || last !== want.last) begin
        fail($sformatf("Byte mismatch: expected value %0d plane %0d last %0d, got %0d %0d %0d",
                       want.value, want.plane, want.last, value, plane, last));
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [RNV_PADDR_W-1:0] paddr;
  logic [RNV_APB_DW-1:0]  pwdata;
  logic [RNV_APB_DW-1:0]  prdata;
  logic                   pready;

  rnv_in_if  in_ch ();
  rnv_out_if out_ch ();

  rgb_to_nv12_upscaling_converter_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nv12_scoreboard nv12_sb;
  int             snd_idle_pct = 0;
  int             rcv_idle_pct = 0;
  int             hold_req = 0;
  int             hold_done = 0;
  int             items_sent = 0;
  int             cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_done != hold_req) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        nv12_sb.note_input(in_ch.action, in_ch.red, in_ch.green, in_ch.blue);
      end
      if (out_ch.valid && out_ch.ready) begin
        nv12_sb.check_result(out_ch.value, out_ch.plane, out_ch.last);
      end
    end
  end

  function automatic logic [23:0] rand_pixel();
    logic [23:0] px;
    case ($urandom_range(7))
      0: px = 24'h000000;
      1: px = 24'hFFFFFF;
      default: px = 24'($urandom());
    endcase
    return px;
  endfunction

  task automatic push_item(logic act, logic [23:0] px);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.red    <= px[23:16];
    in_ch.green  <= px[15:8];
    in_ch.blue   <= px[7:0];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (nv12_sb.expected_bytes.size() != 0);
  endtask

  task automatic apb_write(logic [RNV_REG_IDX_W-1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    nv12_sb.set_reg(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read_check(logic [RNV_REG_IDX_W-1:0] idx, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      nv12_sb.fail($sformatf("Register %0d readback: expected %0d, got %0d", idx, want, prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Register writes start only after some idle cycles with nothing in flight.
  task automatic configure(logic [31:0] w, logic [31:0] h, logic [31:0] s);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    apb_write(REG_SRC_WIDTH, w);
    apb_write(REG_SRC_HEIGHT, h);
    apb_write(REG_SCALE, s);
    apb_read_check(REG_SRC_WIDTH, 32'(w[RNV_DIM_W-1:0]));
    apb_read_check(REG_SRC_HEIGHT, 32'(h[RNV_DIM_W-1:0]));
    apb_read_check(REG_SCALE, 32'(s[RNV_SCALE_W-1:0]));
  endtask

  task automatic run_phase(logic [31:0] w, logic [31:0] h, logic [31:0] s,
                           int unsigned load_cap, int unsigned emit_budget, bit with_pressure);
    int unsigned loads;
    configure(w, h, s);
    loads = nv12_sb.src_w() * nv12_sb.src_h() + 1;
    if (loads > load_cap) loads = load_cap;
    repeat (loads) push_item(ACT_LOAD, rand_pixel());
    for (int i = 0; i < emit_budget; i++) begin
      if (with_pressure && i == emit_budget / 4) hold_req++;
      if (with_pressure && i == emit_budget / 2) wait_drained();
      if ($urandom_range(99) < 6 || !nv12_sb.can_emit()) begin
        push_item(ACT_LOAD, rand_pixel());
      end else begin
        push_item(ACT_EMIT, 24'($urandom()));
      end
    end
  endtask

  task automatic run_random_phase();
    int unsigned w, h, s, img, budget;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    s = $urandom_range(1, 3);
    if ($urandom_range(5) == 0) begin
      w = $urandom_range(1, 2);
      h = $urandom_range(1, 2);
      s = $urandom_range(4, RNV_MAX_SCALE);
    end
    img = (w * s) * (h * s) + ((w * s) + ((w * s) & 1)) * ((h * s + 1) / 2);
    if ($urandom_range(4) == 0) begin
      budget = $urandom_range(5, img);
    end else begin
      budget = img + $urandom_range(0, img / 2);
    end
    if (budget > 220) budget = 220;
    run_phase(w, h, s, 64, budget, 1'b0);
  endtask

  initial begin
    nv12_sb = new();
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Odd scaled width and height: padded chroma row and clamped block samples.
    configure(3, 1, 1);
    push_item(ACT_LOAD, 24'h000000);
    push_item(ACT_LOAD, 24'hFFFFFF);
    push_item(ACT_LOAD, 24'hFF0000);
    push_item(ACT_LOAD, 24'h00FF00);
    repeat (7) push_item(ACT_EMIT, 24'($urandom()));
    configure(2, 2, 1);
    push_item(ACT_LOAD, 24'h0000FF);
    push_item(ACT_LOAD, 24'h808080);
    push_item(ACT_LOAD, 24'hFFFF00);
    push_item(ACT_LOAD, 24'h010203);
    repeat (8) push_item(ACT_EMIT, 24'($urandom()));

    for (int mode = 0; mode < 3; mode++) begin
      snd_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 69 : 0;
      rcv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 32 : 0;
      if (mode == 2) begin
        run_phase(4, 2, 2, 64, 120, 1'b1);
        run_phase(1023, 0, 15, 80, 40, 1'b0);
        run_phase(0, 600, 0, 80, 40, 1'b0);
        run_phase(512, 512, 9, 80, 40, 1'b0);
        run_phase(1, 1, 1, 64, 12, 1'b0);
        run_phase(1, 1, 8, 64, 100, 1'b0);
      end
      while (items_sent < 600 * (mode + 1)) run_random_phase();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (nv12_sb.errors == 0 && nv12_sb.expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
